// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/hmrle_pkg.sv -----
package hmrle_pkg;

  localparam int BYTE_W          = 8;
  localparam int CNT_W           = 32;
  localparam int CODE_LEN_W      = 7;   // length field of a run code
  localparam int MAX_RUN_DEF     = 128;
  localparam int QUEUE_DEPTH_DEF = 4;

  // One request from the front to the back: up to two codes of one item.
  typedef struct packed {
    logic                 cut_vld;    // run closed by mark change or full run
    logic [BYTE_W-1:0]    cut_code;
    logic                 has_last;   // item closes the block
    logic [BYTE_W-1:0]    last_code;
    logic [CNT_W-1:0]     miss_total;
  } hmrle_evt_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } hmrle_qstat_t;

  // Saturating increment of a counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- src/hmrle_in_if.sv -----
interface hmrle_in_if import hmrle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] actual_byte;
  logic [BYTE_W-1:0] predicted_byte;
  logic              is_last;

  modport source (output valid, actual_byte, predicted_byte, is_last, input ready);
  modport sink   (input valid, actual_byte, predicted_byte, is_last, output ready);
endinterface

// ----- src/hmrle_out_if.sv -----
interface hmrle_out_if import hmrle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] run_code;
  logic              code_last;
  logic [CNT_W-1:0]  miss_total;
  logic [CNT_W-1:0]  code_total;

  modport source (output valid, run_code, code_last, miss_total, code_total, input ready);
  modport sink   (input valid, run_code, code_last, miss_total, code_total, output ready);
endinterface

// ----- src/hmrle_front.sv -----
`include "assert_macros.svh"

module hmrle_front import hmrle_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  hmrle_in_if.sink      in_ch,
  input  hmrle_qstat_t  qstat,
  output logic          push,
  output hmrle_evt_t    push_evt
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  logic             run_miss_r, run_miss_nxt;
  logic [RUN_W-1:0] run_len_r,  run_len_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;

  logic             accept;
  logic             miss;
  logic             open_run;
  logic             cut;
  logic             new_miss;
  logic [RUN_W-1:0] new_len;
  logic [CNT_W-1:0] miss_upd;

  // Accept whenever the queue has room
  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the item and track the open run
  always_comb begin
    miss     = (in_ch.actual_byte != in_ch.predicted_byte);
    miss_upd = miss ? sat_inc(miss_cnt_r) : miss_cnt_r;
    open_run = (run_len_r != '0);
    cut      = open_run && ((miss != run_miss_r) || (run_len_r >= RUN_W'(MAX_RUN)));
    if (!open_run || cut) begin
      new_miss = miss;
      new_len  = RUN_W'(1);
    end else begin
      new_miss = run_miss_r;
      new_len  = run_len_r + RUN_W'(1);
    end

    push_evt.cut_vld    = cut;
    push_evt.cut_code   = {run_miss_r, CODE_LEN_W'(run_len_r - RUN_W'(1))};
    push_evt.has_last   = in_ch.is_last;
    push_evt.last_code  = {new_miss, CODE_LEN_W'(new_len - RUN_W'(1))};
    push_evt.miss_total = miss_upd;
    push                = accept && (cut || in_ch.is_last);

    run_miss_nxt = run_miss_r;
    run_len_nxt  = run_len_r;
    miss_cnt_nxt = miss_cnt_r;
    if (accept) begin
      if (in_ch.is_last) begin
        run_miss_nxt = 1'b0;
        run_len_nxt  = '0;
        miss_cnt_nxt = '0;
      end else begin
        run_miss_nxt = new_miss;
        run_len_nxt  = new_len;
        miss_cnt_nxt = miss_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_miss_r <= 1'b0;
      run_len_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      run_miss_r <= run_miss_nxt;
      run_len_r  <= run_len_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  `AST_IMPL(a_run_len_max, clk, rst_n, 1'b1, run_len_r <= RUN_W'(MAX_RUN))
  `AST_IMPL(a_idle_clear, clk, rst_n, run_len_r == '0, (miss_cnt_r == '0) && !run_miss_r)

endmodule

// ----- src/hmrle_queue.sv -----
`include "assert_macros.svh"

module hmrle_queue import hmrle_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hmrle_evt_t    push_evt,
  input  logic          pop,
  output hmrle_evt_t    pop_evt,
  output hmrle_qstat_t  qstat
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCNT_W = $clog2(DEPTH + 1);

  hmrle_evt_t        slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r,    cnt_nxt;

  assign qstat.full  = (cnt_r == QCNT_W'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_evt     = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_evt;
    end
  end

  `AST_IMPL(a_no_overflow, clk, rst_n, push, !qstat.full)
  `AST_IMPL(a_no_underflow, clk, rst_n, pop, !qstat.empty)

endmodule

// ----- src/hmrle_back.sv -----
`include "assert_macros.svh"

module hmrle_back import hmrle_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  hmrle_qstat_t  qstat,
  input  hmrle_evt_t    head_evt,
  output logic          pop,
  hmrle_out_if.source   out_ch
);

  logic              out_vld_r,  out_vld_nxt;
  logic [BYTE_W-1:0] out_code_r, out_code_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CNT_W-1:0]  out_miss_r, out_miss_nxt;
  logic [CNT_W-1:0]  out_ctot_r, out_ctot_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [BYTE_W-1:0] pend_code_r, pend_code_nxt;
  logic [CNT_W-1:0]  pend_miss_r, pend_miss_nxt;
  logic [CNT_W-1:0]  code_cnt_r, code_cnt_nxt;

  logic              load;
  logic [CNT_W-1:0]  cnt_inc;

  assign out_ch.valid      = out_vld_r;
  assign out_ch.run_code   = out_code_r;
  assign out_ch.code_last  = out_last_r;
  assign out_ch.miss_total = out_miss_r;
  assign out_ch.code_total = out_ctot_r;

  // Output register refills when empty or being taken
  assign load    = !out_vld_r || out_ch.ready;
  assign pop     = load && !pend_vld_r && !qstat.empty;
  assign cnt_inc = sat_inc(code_cnt_r);

  // Expand a request into one or two codes
  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    out_miss_nxt  = out_miss_r;
    out_ctot_nxt  = out_ctot_r;
    pend_vld_nxt  = pend_vld_r;
    pend_code_nxt = pend_code_r;
    pend_miss_nxt = pend_miss_r;
    code_cnt_nxt  = code_cnt_r;
    if (load) begin
      if (pend_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_code_nxt = pend_code_r;
        out_last_nxt = 1'b1;
        out_miss_nxt = pend_miss_r;
        out_ctot_nxt = cnt_inc;
        code_cnt_nxt = '0;
        pend_vld_nxt = 1'b0;
      end else if (!qstat.empty) begin
        out_vld_nxt  = 1'b1;
        out_miss_nxt = head_evt.miss_total;
        out_ctot_nxt = cnt_inc;
        if (head_evt.cut_vld) begin
          out_code_nxt  = head_evt.cut_code;
          out_last_nxt  = 1'b0;
          code_cnt_nxt  = cnt_inc;
          pend_vld_nxt  = head_evt.has_last;
          pend_code_nxt = head_evt.last_code;
          pend_miss_nxt = head_evt.miss_total;
        end else begin
          out_code_nxt = head_evt.last_code;
          out_last_nxt = 1'b1;
          code_cnt_nxt = '0;
        end
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      code_cnt_r <= '0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      code_cnt_r <= code_cnt_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
    out_miss_r  <= out_miss_nxt;
    out_ctot_r  <= out_ctot_nxt;
    pend_code_r <= pend_code_nxt;
    pend_miss_r <= pend_miss_nxt;
  end

  `AST_IMPL(a_pend_shown, clk, rst_n, pend_vld_r, out_vld_r && !out_last_r)
  `AST_NEXT(a_last_clears, clk, rst_n, load && pend_vld_r, code_cnt_r == '0)

endmodule

// ----- src/hit_miss_run_length_encoder_unit.sv -----
// Hit/miss run-length encoder.
// Input channel in_ch: one request per byte with the actual byte, the byte a
// predictor guessed, and is_last on the final byte of a block. A byte whose
// two values differ is a miss. Runs of equal marks, at most MAX_RUN long,
// leave on out_ch as one code each: run-1 for hits, 0x80+run-1 for misses,
// with the running miss and code counts of the block (both saturating).
// Throughput: one byte per cycle while the queue is not full. A byte that
// both closes a run and ends the block yields two codes, which occupy the
// output side one after the other; the request queue (QUEUE_DEPTH entries)
// absorbs that. A byte that yields codes writes its request into the queue
// on the edge that accepts it; the output register loads codes from the
// queue head, and a double's second code from the pending register.
// Bytes that only extend a run produce no code.
// Reset (synchronous, rst_n low) clears the open run, both counters, the
// queue and the output register; no code is pending afterwards.
// A stalled receiver holds the output register; the queue keeps taking
// bytes until it fills, then in_ch.ready drops.
module hit_miss_run_length_encoder_unit import hmrle_pkg::*; #(
  parameter int MAX_RUN     = MAX_RUN_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hmrle_in_if.sink    in_ch,
  hmrle_out_if.source out_ch
);

  hmrle_qstat_t qstat;
  hmrle_evt_t   push_evt;
  hmrle_evt_t   head_evt;
  logic         push;
  logic         pop;

  // Classification and run tracking
  hmrle_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .qstat    (qstat),
    .push     (push),
    .push_evt (push_evt)
  );

  // Request queue between front and back
  hmrle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .pop_evt  (head_evt),
    .qstat    (qstat)
  );

  // Code emission and code counting
  hmrle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .head_evt (head_evt),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
